/* hw/rtl/ibst_pkg.sv */
// Shared types, codes and defaults for the indexed binary search tree core.
package ibst_pkg;

  localparam int unsigned MaxNodesDef = 1024;
  localparam int unsigned KeyWidthDef = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned NodeIdxW    = 10;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    req_type_e                 req_type;
    logic signed [DataW-1:0]   key;
    logic signed [DataW-1:0]   value_in;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   value_out;
    logic [NodeIdxW-1:0]       node_index;
  } rsp_t;

  typedef struct packed {
    logic hit;
    logic go_left;
    logic has_child;
  } step_flags_t;

endpackage

/* hw/rtl/ibst_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ibst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/ibst_step.sv */
// One tree walk step: compares the search key with a node word and picks the child.
module ibst_step import ibst_pkg::*; #(
  parameter int unsigned KEY_WIDTH = KeyWidthDef,
  parameter int unsigned IDX_WIDTH = NodeIdxW
) (
  input  logic signed [KEY_WIDTH-1:0]                   key_i,
  input  logic [KEY_WIDTH+DataW+2*(IDX_WIDTH+1)-1:0]    node_word_i,
  output step_flags_t                                   flags_o,
  output logic [IDX_WIDTH-1:0]                          next_o,
  output logic signed [DataW-1:0]                       value_o
);

  localparam int unsigned CW = IDX_WIDTH + 1;
  localparam int unsigned WW = KEY_WIDTH + DataW + 2 * CW;

  logic signed [KEY_WIDTH-1:0] node_key;
  logic [CW-1:0]               left_child;
  logic [CW-1:0]               right_child;
  logic [CW-1:0]               child;

  always_comb begin
    node_key          = node_word_i[WW-1 -: KEY_WIDTH];
    value_o           = node_word_i[WW-KEY_WIDTH-1 -: DataW];
    left_child        = node_word_i[2*CW-1 -: CW];
    right_child       = node_word_i[CW-1:0];
    flags_o.hit       = (key_i == node_key);
    flags_o.go_left   = (key_i < node_key);
    child             = flags_o.go_left ? left_child : right_child;
    flags_o.has_child = child[CW-1];
    next_o            = child[IDX_WIDTH-1:0];
  end

endmodule

/* hw/rtl/indexed_bst_insert_search_core.sv */
// Top level of the indexed binary search tree core: sequencer, node store and result register.
//
// Usage: one request word enters on in_valid_i/in_ready_o (insert a key with a value, or
// search for a key); exactly one response word leaves on out_valid_o/out_ready_i.
// Nodes live in one RAM word each (key, value, left and right child with a valid bit),
// allocated in order; the root is node 0.
// Walk: the sequencer reads one tree level per cycle through the single RAM read port and
// the shared key comparator. The root is read in S_READ, each node is compared in S_CMP while
// the chosen child is read, and the response is handed over in S_DONE; an insert that links
// a new node passes S_NEW and S_LINK before S_DONE; an empty tree skips S_READ and S_CMP.
// Throughput: one request at a time; in_ready_o is high only while the sequencer is idle.
// The response is held in an output register, so a new request is taken while the last
// response still waits; a finished walk waits only if that register is still full.
// Reset clears the node count (the tree is empty) and the output valid; the RAM contents
// are not cleared, since only nodes written since reset are ever read.
// While the receiver stalls, out_word_o is held stable until out_ready_i is seen high.
module indexed_bst_insert_search_core import ibst_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned KEY_WIDTH = KeyWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_word_o
);

  localparam int unsigned IW   = $clog2(MAX_NODES);
  localparam int unsigned CNTW = $clog2(MAX_NODES + 1);
  localparam int unsigned CW   = IW + 1;
  localparam int unsigned WW   = KEY_WIDTH + DataW + 2 * CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_NEW  = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [CNTW-1:0]             count_q, count_d;
  logic                        link_q, link_d;
  logic                        out_valid_q, out_valid_d;
  logic                        is_search_q, is_search_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic signed [DataW-1:0]     val_q, val_d;
  logic [IW-1:0]               pos_q, pos_d;
  logic [WW-1:0]               par_q, par_d;
  rsp_t                        res_q, res_d;
  rsp_t                        out_q, out_d;

  logic                        rd_en, wr_en;
  logic [IW-1:0]               rd_addr, wr_addr;
  logic [WW-1:0]               wr_data, rd_data, new_word;
  step_flags_t                 flags;
  logic [IW-1:0]               next_idx;
  logic signed [DataW-1:0]     node_val;
  logic                        in_acc;

  ibst_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ibst_step #(
    .KEY_WIDTH (KEY_WIDTH),
    .IDX_WIDTH (IW)
  ) u_step (
    .key_i       (key_q),
    .node_word_i (rd_data),
    .flags_o     (flags),
    .next_o      (next_idx),
    .value_o     (node_val)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign new_word   = {key_q, val_q, {CW{1'b0}}, {CW{1'b0}}};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    link_d      = link_q;
    is_search_d = is_search_q;
    key_d       = key_q;
    val_d       = val_q;
    pos_d       = pos_q;
    par_d       = par_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = pos_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IW-1:0];
    wr_data     = new_word;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          is_search_d = (in_word_i.req_type == REQ_SEARCH);
          key_d       = KEY_WIDTH'(in_word_i.key);
          val_d       = in_word_i.value_in;
          pos_d       = '0;
          link_d      = 1'b0;
          if (count_q == '0) begin
            if (in_word_i.req_type == REQ_SEARCH) begin
              res_d.status     = ST_NOT_FOUND;
              res_d.value_out  = '0;
              res_d.node_index = '0;
              state_d          = S_DONE;
            end else begin
              state_d = S_NEW;
            end
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = pos_q;
        state_d = S_CMP;
      end
      S_CMP: begin
        res_d.value_out  = '0;
        res_d.node_index = '0;
        if (flags.hit) begin
          res_d.status     = is_search_q ? ST_FOUND : ST_DUPLICATE;
          res_d.value_out  = is_search_q ? node_val : '0;
          res_d.node_index = NodeIdxW'(pos_q);
          state_d          = S_DONE;
        end else if (flags.has_child) begin
          rd_en   = 1'b1;
          rd_addr = next_idx;
          pos_d   = next_idx;
        end else if (is_search_q) begin
          res_d.status = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else if (count_q == CNTW'(MAX_NODES)) begin
          res_d.status = ST_FULL;
          state_d      = S_DONE;
        end else begin
          if (flags.go_left) begin
            par_d = {rd_data[WW-1:2*CW], 1'b1, count_q[IW-1:0], rd_data[CW-1:0]};
          end else begin
            par_d = {rd_data[WW-1:CW], 1'b1, count_q[IW-1:0]};
          end
          link_d  = 1'b1;
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        wr_en            = 1'b1;
        wr_addr          = count_q[IW-1:0];
        wr_data          = new_word;
        count_d          = count_q + 1'b1;
        res_d.status     = ST_INSERTED;
        res_d.value_out  = '0;
        res_d.node_index = NodeIdxW'(count_q);
        state_d          = link_q ? S_LINK : S_DONE;
      end
      S_LINK: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = par_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      link_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      link_q      <= link_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_search_q <= is_search_d;
    key_q       <= key_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    par_q       <= par_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_NODES))
    else $error("node count above store depth");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_NEW || state_q == S_LINK))
    else $error("node store written outside an insert");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready while a word is in flight");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEW) |=> (count_q == $past(count_q) + 1'b1))
    else $error("node count not advanced on insert");

  a_full_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNTW'(MAX_NODES)) |-> !(state_q == S_NEW))
    else $error("insert into a full store");

endmodule
